// ----- src/stem_mixer_mute_solo_playhead_macros.svh -----
// ----------------------------------------------------------------------------
// Stem mixer assertion macros
// Shared assertion forms for the stem mixer RTL, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef STEM_MIXER_MUTE_SOLO_PLAYHEAD_MACROS_SVH
`define STEM_MIXER_MUTE_SOLO_PLAYHEAD_MACROS_SVH

// Same-cycle implication: when the condition holds, the consequence holds too.
`define SMIX_ASSERT_NOW(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("stem mixer check failed");

// Next-cycle implication: when the condition holds, the consequence holds in the next cycle.
`define SMIX_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("stem mixer check failed");

`endif

// ----- src/smix_pkg.sv -----
// ----------------------------------------------------------------------------
// Stem mixer package
// Sizes, command and register codes, and result types for the stem mixer.
// ----------------------------------------------------------------------------
package smix_pkg;

	// Datapath sizes.
	localparam int NUM_STEMS      = 4;
	localparam int SAMPLE_BITS    = 24;
	localparam int GAIN_FRAC_BITS = 12;
	localparam int GAIN_BITS      = 16;
	localparam int POS_BITS       = 32;
	localparam int STEM_CNT_BITS  = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int MASK_BITS      = 4;

	// Product of a signed sample and a zero-extended gain, and the sum of all stems.
	localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int ACC_BITS  = PROD_BITS + $clog2(NUM_STEMS) + 1;
	localparam int Q_BITS    = ACC_BITS - GAIN_FRAC_BITS;

	// Rounding offset (one half LSB of the result) and saturation limits.
	localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
		{{(ACC_BITS-GAIN_FRAC_BITS){1'b0}}, 1'b1, {(GAIN_FRAC_BITS-1){1'b0}}};
	localparam logic signed [Q_BITS-1:0] SAT_MAX =
		{{(Q_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [Q_BITS-1:0] SAT_MIN = ~SAT_MAX;

	// Unity gain in Q4.12.
	localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;

	// Request commands.
	typedef enum logic [1:0] {
		CMD_FRAME = 2'd0,
		CMD_PLAY  = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_SEEK  = 2'd3
	} cmd_t;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_0 = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_1 = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_2 = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_3 = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MUTE   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SOLO   = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL  = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STEMS  = 3'd7;

	// One saturated channel result.
	typedef struct packed {
		logic                          clip;
		logic signed [SAMPLE_BITS-1:0] val;
	} sat_t;

endpackage

// ----- src/stem_mixer_mute_solo_playhead.sv -----
// ----------------------------------------------------------------------------
// Stem mixer with mute, solo and playhead
// Four-stem stereo mixer with gains, transport commands and a frame playhead.
// ----------------------------------------------------------------------------
// The mixer takes one request per cycle while the output is not stalled; each
// request is registered in stage 1 and its result in the output register. The
// first stage applies the command to the play flag and playhead and works out
// which stems are heard; the second stage forms the eight gain products, sums
// them per channel, rounds and saturates into the output register. Throughput
// is one request per clock while the output is not stalled, set by the two-stage
// pipeline. Configuration writes take effect at once; the user must make them
// while no request is in flight, as the block itself does not enforce this.
`include "stem_mixer_mute_solo_playhead_macros.svh"

module stem_mixer_mute_solo_playhead (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// Configuration write port.
	input  logic                                      cfg_we,
	input  logic [smix_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [smix_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	// Request channel.
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [1:0]                                cmd,
	input  logic signed [smix_pkg::SAMPLE_BITS-1:0]   s0_left,
	input  logic signed [smix_pkg::SAMPLE_BITS-1:0]   s0_right,
	input  logic signed [smix_pkg::SAMPLE_BITS-1:0]   s1_left,
	input  logic signed [smix_pkg::SAMPLE_BITS-1:0]   s1_right,
	input  logic signed [smix_pkg::SAMPLE_BITS-1:0]   s2_left,
	input  logic signed [smix_pkg::SAMPLE_BITS-1:0]   s2_right,
	input  logic signed [smix_pkg::SAMPLE_BITS-1:0]   s3_left,
	input  logic signed [smix_pkg::SAMPLE_BITS-1:0]   s3_right,
	input  logic [smix_pkg::MASK_BITS-1:0]            stem_has_data,
	input  logic [smix_pkg::POS_BITS-1:0]             seek_position,
	// Result channel.
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [smix_pkg::SAMPLE_BITS-1:0]   mix_left,
	output logic signed [smix_pkg::SAMPLE_BITS-1:0]   mix_right,
	output logic                                      is_playing,
	output logic [smix_pkg::POS_BITS-1:0]             play_position,
	output logic                                      clipped
);

	// Configuration registers.
	logic [smix_pkg::GAIN_BITS-1:0]     gain_q [smix_pkg::NUM_STEMS];
	logic [smix_pkg::MASK_BITS-1:0]     mute_q;
	logic [smix_pkg::MASK_BITS-1:0]     solo_q;
	logic [smix_pkg::POS_BITS-1:0]      total_q;
	logic [smix_pkg::STEM_CNT_BITS-1:0] stems_q;

	// Transport state.
	logic                               play_q;
	logic [smix_pkg::POS_BITS-1:0]      head_q;

	// Stage 1 registers.
	logic                                    valid_s1;
	logic signed [smix_pkg::SAMPLE_BITS-1:0] samp_l_s1 [smix_pkg::NUM_STEMS];
	logic signed [smix_pkg::SAMPLE_BITS-1:0] samp_r_s1 [smix_pkg::NUM_STEMS];
	logic [smix_pkg::NUM_STEMS-1:0]          en_s1;
	logic                                    play_s1;
	logic [smix_pkg::POS_BITS-1:0]           pos_s1;

	// Output registers.
	logic                                    out_valid_q;
	logic signed [smix_pkg::SAMPLE_BITS-1:0] mix_left_q;
	logic signed [smix_pkg::SAMPLE_BITS-1:0] mix_right_q;
	logic                                    play_out_q;
	logic [smix_pkg::POS_BITS-1:0]           pos_out_q;
	logic                                    clip_q;

	// Combinational signals.
	logic                                    accept;
	logic                                    adv_out;
	logic                                    play_d;
	logic [smix_pkg::POS_BITS-1:0]           head_d;
	logic                                    mixing;
	logic [smix_pkg::STEM_CNT_BITS-1:0]      stems_eff;
	logic [smix_pkg::NUM_STEMS-1:0]          inuse;
	logic                                    solo_on;
	logic [smix_pkg::NUM_STEMS-1:0]          en_d;
	logic signed [smix_pkg::SAMPLE_BITS-1:0] in_l [smix_pkg::NUM_STEMS];
	logic signed [smix_pkg::SAMPLE_BITS-1:0] in_r [smix_pkg::NUM_STEMS];
	logic signed [smix_pkg::ACC_BITS-1:0]    acc_l;
	logic signed [smix_pkg::ACC_BITS-1:0]    acc_r;
	smix_pkg::sat_t                          fin_l;
	smix_pkg::sat_t                          fin_r;

	// Round half up, drop the fraction bits and saturate to the sample width.
	function automatic smix_pkg::sat_t finish(input logic signed [smix_pkg::ACC_BITS-1:0] acc);
		logic signed [smix_pkg::ACC_BITS-1:0] v;
		logic signed [smix_pkg::Q_BITS-1:0]   q;
		smix_pkg::sat_t                       r;
		v = acc + smix_pkg::ROUND_HALF;
		q = $signed(v[smix_pkg::ACC_BITS-1:smix_pkg::GAIN_FRAC_BITS]);
		r.clip = 1'b0;
		r.val  = q[smix_pkg::SAMPLE_BITS-1:0];
		if (q > smix_pkg::SAT_MAX) begin
			r.clip = 1'b1;
			r.val  = smix_pkg::SAT_MAX[smix_pkg::SAMPLE_BITS-1:0];
		end else if (q < smix_pkg::SAT_MIN) begin
			r.clip = 1'b1;
			r.val  = smix_pkg::SAT_MIN[smix_pkg::SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	// Handshake: stage 1 moves on whenever the output register is free or drained.
	assign adv_out  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_out;
	assign accept   = in_valid && in_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < smix_pkg::NUM_STEMS; s++) begin
				gain_q[s] <= smix_pkg::GAIN_UNITY;
			end
			mute_q  <= '0;
			solo_q  <= '0;
			total_q <= '0;
			stems_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				smix_pkg::CFG_GAIN_0: gain_q[0] <= cfg_data[smix_pkg::GAIN_BITS-1:0];
				smix_pkg::CFG_GAIN_1: gain_q[1] <= cfg_data[smix_pkg::GAIN_BITS-1:0];
				smix_pkg::CFG_GAIN_2: gain_q[2] <= cfg_data[smix_pkg::GAIN_BITS-1:0];
				smix_pkg::CFG_GAIN_3: gain_q[3] <= cfg_data[smix_pkg::GAIN_BITS-1:0];
				smix_pkg::CFG_MUTE:   mute_q    <= cfg_data[smix_pkg::MASK_BITS-1:0];
				smix_pkg::CFG_SOLO:   solo_q    <= cfg_data[smix_pkg::MASK_BITS-1:0];
				smix_pkg::CFG_TOTAL:  total_q   <= cfg_data[smix_pkg::POS_BITS-1:0];
				smix_pkg::CFG_STEMS:  stems_q   <= cfg_data[smix_pkg::STEM_CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Collect the stem samples so that the stems can be walked by index.
	assign in_l[0] = s0_left;
	assign in_r[0] = s0_right;
	assign in_l[1] = s1_left;
	assign in_r[1] = s1_right;
	assign in_l[2] = s2_left;
	assign in_r[2] = s2_right;
	assign in_l[3] = s3_left;
	assign in_r[3] = s3_right;

	// Stems heard this frame: only on a mixing frame, and in use, unmuted, with data, and passing the solo rule.
	always_comb begin
		stems_eff = (stems_q > smix_pkg::STEM_CNT_BITS'(smix_pkg::NUM_STEMS)) ?
			smix_pkg::STEM_CNT_BITS'(smix_pkg::NUM_STEMS) : stems_q;
		for (int s = 0; s < smix_pkg::NUM_STEMS; s++) begin
			inuse[s] = smix_pkg::STEM_CNT_BITS'(s) < stems_eff;
		end
		solo_on = |(solo_q & inuse);
		for (int s = 0; s < smix_pkg::NUM_STEMS; s++) begin
			en_d[s] = mixing && inuse[s] && !mute_q[s] && stem_has_data[s] &&
				(!solo_on || solo_q[s]);
		end
	end

	// Transport: next play flag and playhead for the request being accepted.
	always_comb begin
		play_d = play_q;
		head_d = head_q;
		mixing = 1'b0;
		case (smix_pkg::cmd_t'(cmd))
			smix_pkg::CMD_PLAY: begin
				play_d = 1'b1;
			end
			smix_pkg::CMD_STOP: begin
				play_d = 1'b0;
				head_d = '0;
			end
			smix_pkg::CMD_SEEK: begin
				head_d = (seek_position < total_q) ? seek_position : total_q;
			end
			smix_pkg::CMD_FRAME: begin
				if (play_q && (stems_q != '0)) begin
					if (head_q >= total_q) begin
						play_d = 1'b0;
					end else begin
						mixing = 1'b1;
						head_d = head_q + smix_pkg::POS_BITS'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Transport state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_q <= 1'b0;
			head_q <= '0;
		end else if (accept) begin
			play_q <= play_d;
			head_q <= head_d;
		end
	end

	// Stage 1: the accepted request with its stem enables and transport state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int s = 0; s < smix_pkg::NUM_STEMS; s++) begin
				samp_l_s1[s] <= in_l[s];
				samp_r_s1[s] <= in_r[s];
			end
			en_s1   <= en_d;
			play_s1 <= play_d;
			pos_s1  <= head_d;
		end
	end

	// Stage 2: gain products of the enabled stems, summed per channel.
	always_comb begin
		acc_l = '0;
		acc_r = '0;
		for (int s = 0; s < smix_pkg::NUM_STEMS; s++) begin
			if (en_s1[s]) begin
				acc_l = acc_l + smix_pkg::ACC_BITS'(samp_l_s1[s] * $signed({1'b0, gain_q[s]}));
				acc_r = acc_r + smix_pkg::ACC_BITS'(samp_r_s1[s] * $signed({1'b0, gain_q[s]}));
			end
		end
		fin_l = finish(acc_l);
		fin_r = finish(acc_r);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			mix_left_q  <= fin_l.val;
			mix_right_q <= fin_r.val;
			clip_q      <= fin_l.clip || fin_r.clip;
			play_out_q  <= play_s1;
			pos_out_q   <= pos_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign mix_left      = mix_left_q;
	assign mix_right     = mix_right_q;
	assign clipped       = clip_q;
	assign is_playing    = play_out_q;
	assign play_position = pos_out_q;

	// A full stage 1 behind a stalled output must hold off new requests.
	`SMIX_ASSERT_NOW(a_stall_blocks_input, valid_s1 && out_valid_q && !out_ready, !in_ready)
	// A stop request rewinds and stops the transport.
	`SMIX_ASSERT_NEXT(a_stop_rewinds, accept && (cmd == smix_pkg::CMD_STOP), !play_q && (head_q == '0))
	// A play request sets the play flag and leaves the playhead alone.
	`SMIX_ASSERT_NEXT(a_play_sets_flag, accept && (cmd == smix_pkg::CMD_PLAY),
		play_q && (head_q == $past(head_q)))
	// A clipped result sits at a saturation limit on at least one channel.
	`SMIX_ASSERT_NOW(a_clip_at_limit, out_valid_q && clip_q,
		(mix_left_q == smix_pkg::SAT_MAX[smix_pkg::SAMPLE_BITS-1:0]) ||
		(mix_left_q == smix_pkg::SAT_MIN[smix_pkg::SAMPLE_BITS-1:0]) ||
		(mix_right_q == smix_pkg::SAT_MAX[smix_pkg::SAMPLE_BITS-1:0]) ||
		(mix_right_q == smix_pkg::SAT_MIN[smix_pkg::SAMPLE_BITS-1:0]))

endmodule
